@@ rtl/hfb_pkg.sv @@
`default_nettype none
package hfb_pkg;

    localparam int MaxGenotypes = 128;
    localparam int MaxVisited   = 1024;
    localparam int ProbBits     = 32;
    localparam int GenoBits     = 7;
    localparam int VisBits      = 10;
    localparam int CountBits    = 11;
    localparam int TableBits    = 14;
    localparam int CfgIdxBits   = 3;
    localparam int CfgDataBits  = 11;
    localparam int QueueDepth   = 2;

    typedef enum logic [2:0] {
        OP_LOAD_TRANS  = 3'd0,
        OP_LOAD_KNOWN  = 3'd1,
        OP_LOAD_SOURCE = 3'd2,
        OP_LOAD_TARGET = 3'd3,
        OP_LOAD_EMIT   = 3'd4,
        OP_RUN         = 3'd5,
        OP_NONE6       = 3'd6,
        OP_NONE7       = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CFG_DIRECTION    = 3'd0,
        CFG_USE_EMISSION = 3'd1,
        CFG_TWO_PARENTS  = 3'd2,
        CFG_SOURCE_COUNT = 3'd3,
        CFG_TARGET_COUNT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]          op;
        logic [TableBits-1:0] addr;
        logic [ProbBits-1:0] prob_value;
        logic [GenoBits-1:0] index_p;
        logic [GenoBits-1:0] index_q;
    } in_item_t;

    typedef struct packed {
        logic [ProbBits-1:0] result_value;
        logic [VisBits-1:0]  result_index;
        logic                saturated;
    } out_item_t;

    typedef struct packed {
        logic                 direction;
        logic                 use_emission;
        logic                 two_parents;
        logic [CountBits-1:0] n_src;
        logic [CountBits-1:0] n_tgt;
    } cfg_t;

    // command classified by the front end
    typedef struct packed {
        logic                 is_run;
        logic [2:0]           op;
        logic [TableBits-1:0] addr;
        logic [ProbBits-1:0]  prob_value;
        logic [GenoBits-1:0]  index_p;
        logic [GenoBits-1:0]  index_q;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_LOOP  = 2'd2,
        ST_FINAL = 2'd3
    } state_t;

    function automatic logic [CountBits-1:0] clip_count(input logic [CountBits-1:0] c);
        logic [CountBits-1:0] r;
        r = c;
        if (c > CountBits'(MaxVisited))
        begin
            r = CountBits'(MaxVisited);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/hfb_front.sv @@
`default_nettype none
module hfb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hfb_pkg::in_item_t in_item,
    input  wire hfb_pkg::cfg_t    cfg,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output hfb_pkg::cmd_t         cmd
);

    hfb_pkg::cmd_t q_reg [hfb_pkg::QueueDepth];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          keep;
    logic          push, pop;
    logic [hfb_pkg::CountBits-1:0] lim;

    // drop items that give neither a store write nor a result
    always_comb
    begin
        lim = cfg.direction ? hfb_pkg::clip_count(cfg.n_src)
                            : hfb_pkg::clip_count(cfg.n_tgt);
        case (in_item.op)
            hfb_pkg::OP_LOAD_TRANS: keep = 1'b1;
            hfb_pkg::OP_LOAD_KNOWN, hfb_pkg::OP_LOAD_SOURCE,
            hfb_pkg::OP_LOAD_TARGET, hfb_pkg::OP_LOAD_EMIT:
                keep = (in_item.addr < hfb_pkg::TableBits'(hfb_pkg::MaxVisited));
            hfb_pkg::OP_RUN:
                keep = ({3'b0, in_item.addr} < {6'b0, lim}) ;
            default: keep = 1'b0;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg].is_run     <= (in_item.op == hfb_pkg::OP_RUN);
            q_reg[wr_ptr_reg].op         <= in_item.op;
            q_reg[wr_ptr_reg].addr       <= in_item.addr;
            q_reg[wr_ptr_reg].prob_value <= in_item.prob_value;
            q_reg[wr_ptr_reg].index_p    <= in_item.index_p;
            q_reg[wr_ptr_reg].index_q    <= in_item.index_q;
        end
    end

endmodule
`default_nettype wire

@@ rtl/hfb_back.sv @@
`default_nettype none
module hfb_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hfb_pkg::cfg_t     cfg,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire hfb_pkg::cmd_t     cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hfb_pkg::out_item_t     out_item,
    output logic                   busy
);

    localparam int PB = hfb_pkg::ProbBits;
    localparam int VB = hfb_pkg::VisBits;
    localparam int GB = hfb_pkg::GenoBits;

    logic [PB-1:0]     trans_mem [hfb_pkg::MaxGenotypes*hfb_pkg::MaxGenotypes];
    logic [PB-1:0]     known_mem [hfb_pkg::MaxVisited];
    logic [PB-1:0]     emit_mem  [hfb_pkg::MaxVisited];
    logic [2*GB-1:0]   src_mem   [hfb_pkg::MaxVisited];
    logic [2*GB-1:0]   tgt_mem   [hfb_pkg::MaxVisited];

    hfb_pkg::state_t state_reg, state_next;

    logic [hfb_pkg::CountBits-1:0] i_reg, i_next, n_reg, n_next;
    logic [VB-1:0]   run_addr_reg, run_addr_next;
    logic            dir_reg, emit_en_reg, two_reg;
    logic [2*GB-1:0] fixed_pair_reg;

    // pipeline: s1 index reads, s2 trans/known/emit reads, s3 pq mult,
    // s4 known mult, s5 emission mult (backward), s6 accumulate
    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [2*GB-1:0] pair1_reg;
    logic [PB-1:0]   tp_reg, tq_reg, kn_reg, em2_reg;
    logic [PB-1:0]   kn3_reg;
    logic [PB-1:0]   em3_reg, em4_reg;
    logic [PB-1:0]   f3_reg, t4_reg, t5_reg;
    logic [PB-1:0]   acc_reg, acc_next;
    logic            sat_reg, sat_next;
    logic [PB-1:0]   emit_final_reg;
    logic [PB-1:0]   fin_reg;
    logic            fin_phase_reg;

    logic            out_valid_reg;
    hfb_pkg::out_item_t out_reg;

    logic            loop_issue;
    logic            drain_done;
    logic [VB-1:0]   i_idx;
    logic [VB-1:0]   i1_reg;
    logic [GB-1:0]   sp, sq, tp_i, tq_i;
    logic [2*PB-1:0] prod_pq, prod_k, prod_e, prod_f;
    logic [PB:0]     sum;

    assign i_idx      = i_reg[VB-1:0];
    assign loop_issue = (state_reg == hfb_pkg::ST_LOOP) && (i_reg < n_reg);
    assign drain_done = (state_reg == hfb_pkg::ST_LOOP) && (i_reg >= n_reg)
                        && !v1_reg && !v2_reg && !v3_reg && !v4_reg && !v5_reg;

    // store writes
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && !cmd.is_run)
        begin
            unique case (cmd.op)
                hfb_pkg::OP_LOAD_TRANS:  trans_mem[cmd.addr] <= cmd.prob_value;
                hfb_pkg::OP_LOAD_KNOWN:  known_mem[cmd.addr[VB-1:0]] <= cmd.prob_value;
                hfb_pkg::OP_LOAD_SOURCE: src_mem[cmd.addr[VB-1:0]] <= {cmd.index_p, cmd.index_q};
                hfb_pkg::OP_LOAD_TARGET: tgt_mem[cmd.addr[VB-1:0]] <= {cmd.index_p, cmd.index_q};
                hfb_pkg::OP_LOAD_EMIT:   emit_mem[cmd.addr[VB-1:0]] <= cmd.prob_value;
                default: ;
            endcase
        end
    end

    // fixed side read and final emission read at setup
    always_ff @(posedge clk)
    begin
        if (state_reg == hfb_pkg::ST_SETUP)
        begin
            fixed_pair_reg <= dir_reg ? src_mem[run_addr_reg] : tgt_mem[run_addr_reg];
            emit_final_reg <= emit_mem[run_addr_reg];
        end
    end

    // stage 1: varying index pair
    always_ff @(posedge clk)
    begin
        pair1_reg <= dir_reg ? tgt_mem[i_idx] : src_mem[i_idx];
    end

    always_ff @(posedge clk)
    begin
        i1_reg <= i_idx;
    end

    always_comb
    begin
        if (dir_reg)
        begin
            sp   = fixed_pair_reg[2*GB-1:GB];
            sq   = fixed_pair_reg[GB-1:0];
            tp_i = pair1_reg[2*GB-1:GB];
            tq_i = pair1_reg[GB-1:0];
        end
        else
        begin
            sp   = pair1_reg[2*GB-1:GB];
            sq   = pair1_reg[GB-1:0];
            tp_i = fixed_pair_reg[2*GB-1:GB];
            tq_i = fixed_pair_reg[GB-1:0];
        end
    end

    // stage 2: table, known and emission reads
    always_ff @(posedge clk)
    begin
        tp_reg  <= trans_mem[{sp, tp_i}];
        tq_reg  <= trans_mem[{sq, tq_i}];
        kn_reg  <= known_mem[i1_reg];
        em2_reg <= emit_mem[i1_reg];
    end

    assign prod_pq = tp_reg * tq_reg;
    assign prod_k  = kn3_reg * f3_reg;
    assign prod_e  = t4_reg * em4_reg;
    assign prod_f  = fin_reg * emit_final_reg;

    always_ff @(posedge clk)
    begin
        f3_reg  <= two_reg ? prod_pq[2*PB-1:PB] : tp_reg;
        em3_reg <= em2_reg;
        t4_reg  <= prod_k[2*PB-1:PB];
        em4_reg <= em3_reg;
        t5_reg  <= (dir_reg && emit_en_reg) ? prod_e[2*PB-1:PB] : t4_reg;
    end

    // kn_reg pairs with f3_reg one stage later, so known is delayed through kn3_reg
    always_ff @(posedge clk)
    begin
        kn3_reg <= kn_reg;
    end

    assign sum = {1'b0, acc_reg} + {1'b0, t5_reg};

    always_comb
    begin
        acc_next = acc_reg;
        sat_next = sat_reg;
        if (state_reg == hfb_pkg::ST_SETUP)
        begin
            acc_next = '0;
            sat_next = 1'b0;
        end
        else if (v5_reg)
        begin
            if (sum[PB])
            begin
                acc_next = '1;
                sat_next = 1'b1;
            end
            else
            begin
                acc_next = sum[PB-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hfb_pkg::ST_IDLE:
                if (cmd_valid && cmd.is_run)
                begin
                    state_next = hfb_pkg::ST_SETUP;
                end
            hfb_pkg::ST_SETUP: state_next = hfb_pkg::ST_LOOP;
            hfb_pkg::ST_LOOP:
                if (drain_done)
                begin
                    state_next = hfb_pkg::ST_FINAL;
                end
            hfb_pkg::ST_FINAL:
                if (!out_valid_reg && fin_phase_reg)
                begin
                    state_next = hfb_pkg::ST_IDLE;
                end
            default: state_next = hfb_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready     = 1'b0;
        i_next        = i_reg;
        n_next        = n_reg;
        run_addr_next = run_addr_reg;
        unique case (state_reg)
            hfb_pkg::ST_IDLE:
            begin
                cmd_ready     = cmd_valid;
                run_addr_next = cmd.addr[VB-1:0];
                i_next        = '0;
                n_next        = cfg.direction ? hfb_pkg::clip_count(cfg.n_tgt)
                                              : hfb_pkg::clip_count(cfg.n_src);
            end
            hfb_pkg::ST_LOOP:
                if (loop_issue)
                begin
                    i_next = i_reg + 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hfb_pkg::ST_IDLE;
            i_reg         <= '0;
            n_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            fin_phase_reg <= 1'b0;
            dir_reg       <= 1'b0;
            emit_en_reg   <= 1'b0;
            two_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            v1_reg    <= loop_issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            if (state_reg == hfb_pkg::ST_IDLE)
            begin
                dir_reg     <= cfg.direction;
                emit_en_reg <= cfg.use_emission;
                two_reg     <= cfg.two_parents;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == hfb_pkg::ST_FINAL && !fin_phase_reg)
            begin
                fin_phase_reg <= 1'b1;
            end
            else if (state_reg == hfb_pkg::ST_FINAL && fin_phase_reg && !out_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                fin_phase_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sat_reg      <= sat_next;
        run_addr_reg <= run_addr_next;
        if (state_reg == hfb_pkg::ST_FINAL && !fin_phase_reg)
        begin
            fin_reg <= acc_reg;
        end
        if (state_reg == hfb_pkg::ST_FINAL && fin_phase_reg && !out_valid_reg)
        begin
            out_reg.result_value <= (!dir_reg && emit_en_reg) ? prod_f[2*PB-1:PB] : fin_reg;
            out_reg.result_index <= run_addr_reg;
            out_reg.saturated    <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign busy      = (state_reg != hfb_pkg::ST_IDLE) || out_valid_reg;

endmodule
`default_nettype wire

@@ rtl/hmm_forward_backward_step.sv @@
`default_nettype none
// One forward or backward HMM recursion step over sparse visited states. Load
// items (op 0..4) write the transition table, known vector, source/target index
// lists and emission vector; a run item (op 5) returns one element in unsigned
// Q0.32 with a saturation flag. A run covers n visited states, n being
// source_count (forward) or target_count (backward): one multiply-accumulate
// per visited state through a six-stage pipeline. A two-entry queue separates
// input from the engine.
module hmm_forward_backward_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hfb_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hfb_pkg::out_item_t      out_item,
    input  wire logic               cfg_we,
    input  wire logic [hfb_pkg::CfgIdxBits-1:0]  cfg_index,
    input  wire logic [hfb_pkg::CfgDataBits-1:0] cfg_data
);

    hfb_pkg::cfg_t cfg_reg;
    hfb_pkg::cmd_t cmd;
    logic          cmd_valid, cmd_ready, busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction    <= 1'b0;
            cfg_reg.use_emission <= 1'b1;
            cfg_reg.two_parents  <= 1'b1;
            cfg_reg.n_src        <= hfb_pkg::CountBits'(1);
            cfg_reg.n_tgt        <= hfb_pkg::CountBits'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hfb_pkg::CFG_DIRECTION:    cfg_reg.direction    <= cfg_data[0];
                hfb_pkg::CFG_USE_EMISSION: cfg_reg.use_emission <= cfg_data[0];
                hfb_pkg::CFG_TWO_PARENTS:  cfg_reg.two_parents  <= cfg_data[0];
                hfb_pkg::CFG_SOURCE_COUNT: cfg_reg.n_src        <= cfg_data;
                hfb_pkg::CFG_TARGET_COUNT: cfg_reg.n_tgt        <= cfg_data;
                default: ;
            endcase
        end
    end

    hfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    hfb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .busy      (busy)
    );

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !out_valid) |-> !cmd_ready)
        else $error("engine took a command while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
        else $error("result dropped while stalled");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.saturated && !cfg_reg.use_emission)
            |-> (out_item.result_value == '1))
        else $error("saturated result below max");

endmodule
`default_nettype wire
